// ----- rtl/acpu_pkg.sv -----
// Shared types, opcodes, microcode table and ALU for the accumulator processor.
`timescale 1ns / 1ps

package acpu_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_START = 2'd2,
    KIND_RUN   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_CMP = 4'd1,
    OP_LDA = 4'd2,
    OP_MOV = 4'd3,
    OP_JMP = 4'd4,
    OP_JEZ = 4'd5,
    OP_JPS = 4'd6,
    OP_HLT = 4'd7,
    OP_INC = 4'd8,
    OP_DEC = 4'd9,
    OP_AND = 4'd10,
    OP_IOR = 4'd11,
    OP_SHL = 4'd12,
    OP_SHR = 4'd13,
    OP_MXF = 4'd14,
    OP_MXT = 4'd15
  } op_e;

  typedef enum logic [4:0] {
    U_IDLE,
    U_WR,
    U_RD,
    U_RDCAP,
    U_START,
    U_FETCH,
    U_DISP,
    U_ALU,
    U_JMP,
    U_OPND,
    U_IND,
    U_STN,
    U_FLN,
    U_XF0,
    U_XF1,
    U_XT0,
    U_XT1,
    U_XW,
    U_FIN
  } upc_e;

  typedef enum logic [1:0] {M_NONE, M_READ, M_WRITE} mop_e;
  typedef enum logic [2:0] {A_IN, A_PC, A_MEMQ, A_N, A_IX, A_ZERO, A_TWO} asel_e;
  typedef enum logic [1:0] {D_IN, D_MEMQ, D_ALU, D_IX} dsel_e;
  typedef enum logic [1:0] {P_HOLD, P_INC, P_LOAD, P_BRANCH} pcop_e;
  typedef enum logic [1:0] {F_NONE, F_ALU, F_LDA, F_ZSA} flg_e;
  typedef enum logic [2:0] {SQ_IDLE, SQ_GOTO, SQ_DISP, SQ_IFMOV, SQ_FIN} seq_e;

  typedef struct packed {
    mop_e  mop;
    asel_e asel;
    dsel_e dsel;
    pcop_e pc_op;
    flg_e  flg;
    logic  set_ir;
    logic  cap_rd;
    logic  clr_halt;
    logic  ix_inc;
    seq_e  seq;
    upc_e  next;
  } ctl_t;

  typedef struct packed {
    logic [15:0] res;
    logic        z;
    logic        s;
    logic        c;
    logic        f;
    logic        wz;
    logic        ws;
    logic        wcf;
  } alu_t;

  localparam logic [15:0] SIGN_MASK = 16'h8000;
  localparam logic [15:0] ALL_ONES  = 16'hFFFF;
  localparam logic [2:0]  CYC_SHORT = 3'd3;
  localparam logic [2:0]  CYC_MID   = 3'd5;
  localparam logic [2:0]  CYC_LONG  = 3'd7;

  localparam ctl_t CTL_NOP = '{
    mop: M_NONE, asel: A_PC, dsel: D_IN, pc_op: P_HOLD, flg: F_NONE,
    set_ir: 1'b0, cap_rd: 1'b0, clr_halt: 1'b0, ix_inc: 1'b0,
    seq: SQ_GOTO, next: U_FIN
  };

  function automatic ctl_t ucode(upc_e upc);
    ctl_t c;
    c = CTL_NOP;
    unique case (upc)
      U_WR: begin
        c.mop = M_WRITE; c.asel = A_IN; c.dsel = D_IN;
      end
      U_RD: begin
        c.mop = M_READ; c.asel = A_IN; c.next = U_RDCAP;
      end
      U_RDCAP: c.cap_rd = 1'b1;
      U_START: begin
        c.pc_op = P_LOAD; c.clr_halt = 1'b1;
      end
      U_FETCH: begin
        c.mop = M_READ; c.asel = A_PC; c.next = U_DISP;
      end
      U_DISP: begin
        c.set_ir = 1'b1; c.pc_op = P_INC; c.seq = SQ_DISP;
      end
      U_ALU: begin
        c.mop = M_WRITE; c.asel = A_ZERO; c.dsel = D_ALU; c.flg = F_ALU;
      end
      U_JMP: c.pc_op = P_BRANCH;
      U_OPND: begin
        c.mop = M_READ; c.asel = A_PC; c.pc_op = P_INC;
        c.seq = SQ_IFMOV; c.next = U_STN;
      end
      U_IND: begin
        c.mop = M_READ; c.asel = A_MEMQ; c.next = U_STN;
      end
      U_STN: begin
        c.mop = M_WRITE; c.asel = A_N; c.dsel = D_MEMQ; c.next = U_FLN;
      end
      U_FLN: c.flg = F_LDA;
      U_XF0: begin
        c.mop = M_READ; c.asel = A_IX; c.next = U_XF1;
      end
      U_XF1: begin
        c.mop = M_WRITE; c.asel = A_N; c.dsel = D_MEMQ; c.ix_inc = 1'b1;
        c.next = U_XW;
      end
      U_XT0: begin
        c.mop = M_READ; c.asel = A_N; c.next = U_XT1;
      end
      U_XT1: begin
        c.mop = M_WRITE; c.asel = A_IX; c.dsel = D_MEMQ; c.ix_inc = 1'b1;
        c.next = U_XW;
      end
      U_XW: begin
        c.mop = M_WRITE; c.asel = A_TWO; c.dsel = D_IX; c.flg = F_ZSA;
      end
      U_FIN: c.seq = SQ_FIN;
      default: c.seq = SQ_IDLE;
    endcase
    return c;
  endfunction

  function automatic upc_e dispatch(op_e op);
    upc_e u;
    unique case (op)
      OP_LDA, OP_MOV:                 u = U_OPND;
      OP_JMP, OP_JEZ, OP_JPS, OP_HLT: u = U_JMP;
      OP_MXF:                         u = U_XF0;
      OP_MXT:                         u = U_XT0;
      default:                        u = U_ALU;
    endcase
    return u;
  endfunction

  function automatic logic [2:0] op_cycles(op_e op);
    logic [2:0] n;
    unique case (op)
      OP_MOV:                 n = CYC_LONG;
      OP_LDA, OP_MXF, OP_MXT: n = CYC_MID;
      default:                n = CYC_SHORT;
    endcase
    return n;
  endfunction

  function automatic alu_t alu(op_e op, logic [15:0] a, logic [15:0] b);
    alu_t        r;
    logic [15:0] opnd;
    logic [16:0] sum;
    r = '0;
    unique case (op)
      OP_INC:  opnd = 16'd1;
      OP_DEC:  opnd = ALL_ONES;
      default: opnd = b;
    endcase
    sum = {1'b0, a} + {1'b0, opnd};
    unique case (op)
      OP_ADD, OP_INC, OP_DEC: begin
        r.res = sum[15:0];
        r.c   = sum[16];
        r.f   = ((~(a ^ opnd)) & (a ^ sum[15:0]) & SIGN_MASK) != 16'd0;
        r.wz  = 1'b1; r.ws = 1'b1; r.wcf = 1'b1;
      end
      OP_CMP: begin
        r.res = ~a; r.wz = 1'b1; r.ws = 1'b1;
      end
      OP_AND: begin
        r.res = a & b; r.wz = 1'b1;
      end
      OP_IOR: begin
        r.res = a | b; r.wz = 1'b1;
      end
      OP_SHL: begin
        r.res = {a[14:0], 1'b0}; r.wz = 1'b1; r.ws = 1'b1;
      end
      OP_SHR: begin
        r.res = {a[15], a[15:1]}; r.wz = 1'b1; r.ws = 1'b1;
      end
      default: r.res = a;
    endcase
    r.z = (r.res == 16'd0);
    r.s = r.res[15];
    return r;
  endfunction

endpackage

// ----- rtl/acpu_ram.sv -----
// Single-port word memory with registered read data.
`timescale 1ns / 1ps

module acpu_ram #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [15:0]              wdata_i,
  output logic [15:0]              rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/accumulator_cpu_16bit_core.sv -----
// Top level of the 16-bit accumulator processor: microcode sequencer and datapath.
`timescale 1ns / 1ps
//
// Input channel (in_valid_i / in_stall_o) carries one action per beat: write a
// memory word, read a memory word, start at an address, or run one instruction.
// Output channel (out_valid_o / out_stall_i) returns one result beat per action:
// read data, PC, accumulator, flags, halt and the modelled instruction cycles.
// Words 0, 1 and 2 of memory are mirrored in registers (A, B, IX).
// A microcode table drives the datapath one step per clock over a single memory
// port, except that the final step waits while a result is held and the
// receiver stalls; the result beat loads as that step ends. Each action runs
// the steps of its kind: write; read and capture; start; or a run that fetches,
// dispatches and executes one instruction, or goes straight to the final step
// while halted. The next input beat is taken once the sequencer is back at idle.
// After reset the block sweeps all MEM_DEPTH words of memory to zero, one word
// per cycle; in_stall_o stays high during the sweep.
// The result sits in an output register: while the receiver stalls, the next
// input beat is still taken and worked up to its final step, where it waits.

module accumulator_cpu_16bit_core #(
  parameter int MEM_DEPTH = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [12:0] address_i,
  input  logic [15:0] data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic [12:0] program_counter_o,
  output logic [15:0] accumulator_o,
  output logic        zero_flag_o,
  output logic        sign_flag_o,
  output logic        carry_flag_o,
  output logic        overflow_flag_o,
  output logic        halted_o,
  output logic [2:0]  cycles_used_o
);

  localparam int          AW      = $clog2(MEM_DEPTH);
  localparam logic [13:0] DEPTH14 = 14'(MEM_DEPTH);

  function automatic logic [AW-1:0] mem_index(logic [12:0] a);
    logic [13:0] ext;
    logic [13:0] sub;
    ext = {1'b0, a};
    sub = ext - DEPTH14;
    return (ext >= DEPTH14) ? sub[AW-1:0] : ext[AW-1:0];
  endfunction

  acpu_pkg::upc_e upc_q, upc_d;
  acpu_pkg::ctl_t ctl;
  acpu_pkg::alu_t alu_r;
  acpu_pkg::op_e  ir_op;

  logic          clearing_q;
  logic [AW-1:0] clr_q;
  logic          in_accept;
  logic          out_load;
  logic          out_valid_q;

  logic [12:0] addr_q;
  logic [15:0] data_q;
  logic [15:0] ir_q;
  logic [15:0] rdata_q;
  logic [2:0]  cycles_q;

  logic [12:0] pc_q, pc_d;
  logic [15:0] a_q, a_d, b_q, b_d, ix_q, ix_d;
  logic        z_q, z_d, s_q, s_d, c_q, c_d, f_q, f_d;
  logic        halt_q, halt_d;

  logic [12:0]   raw_addr;
  logic [AW-1:0] op_idx;
  logic [AW-1:0] ram_addr;
  logic [15:0]   wdata;
  logic [15:0]   ram_wdata;
  logic [15:0]   mem_q;
  logic          ram_we;
  logic          ram_re;
  logic          n_zero;

  assign ctl       = acpu_pkg::ucode(upc_q);
  assign ir_op     = acpu_pkg::op_e'(ir_q[15:12]);
  assign alu_r     = acpu_pkg::alu(ir_op, a_q, b_q);
  assign n_zero    = (ir_q[11:0] == 12'd0);
  assign in_stall_o = clearing_q || (upc_q != acpu_pkg::U_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = (ctl.seq == acpu_pkg::SQ_FIN) && (!out_valid_q || !out_stall_i);

  // Next step of the sequencer.
  always_comb begin
    upc_d = upc_q;
    unique case (ctl.seq)
      acpu_pkg::SQ_IDLE: begin
        if (in_accept) begin
          unique case (acpu_pkg::kind_e'(kind_i))
            acpu_pkg::KIND_WRITE: upc_d = acpu_pkg::U_WR;
            acpu_pkg::KIND_READ:  upc_d = acpu_pkg::U_RD;
            acpu_pkg::KIND_START: upc_d = acpu_pkg::U_START;
            default:              upc_d = halt_q ? acpu_pkg::U_FIN : acpu_pkg::U_FETCH;
          endcase
        end
      end
      acpu_pkg::SQ_GOTO:  upc_d = ctl.next;
      acpu_pkg::SQ_DISP:  upc_d = acpu_pkg::dispatch(acpu_pkg::op_e'(mem_q[15:12]));
      acpu_pkg::SQ_IFMOV: upc_d = (ir_op == acpu_pkg::OP_MOV) ? acpu_pkg::U_IND : ctl.next;
      acpu_pkg::SQ_FIN:   upc_d = out_load ? acpu_pkg::U_IDLE : acpu_pkg::U_FIN;
      default:            upc_d = acpu_pkg::U_IDLE;
    endcase
  end

  // Memory address and write data.
  always_comb begin
    unique case (ctl.asel)
      acpu_pkg::A_IN:   raw_addr = addr_q;
      acpu_pkg::A_PC:   raw_addr = pc_q;
      acpu_pkg::A_MEMQ: raw_addr = mem_q[12:0];
      acpu_pkg::A_N:    raw_addr = {1'b0, ir_q[11:0]};
      acpu_pkg::A_IX:   raw_addr = ix_q[12:0];
      acpu_pkg::A_TWO:  raw_addr = 13'd2;
      default:          raw_addr = 13'd0;
    endcase
    unique case (ctl.dsel)
      acpu_pkg::D_IN:   wdata = data_q;
      acpu_pkg::D_MEMQ: wdata = mem_q;
      acpu_pkg::D_ALU:  wdata = alu_r.res;
      default:          wdata = ix_q;
    endcase
  end

  assign op_idx    = mem_index(raw_addr);
  assign ram_addr  = clearing_q ? clr_q : op_idx;
  assign ram_wdata = clearing_q ? 16'd0 : wdata;
  assign ram_we    = clearing_q || (ctl.mop == acpu_pkg::M_WRITE);
  assign ram_re    = !clearing_q && (ctl.mop == acpu_pkg::M_READ);

  acpu_ram #(
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (mem_q)
  );

  // Mirrors of words 0, 1 and 2.
  always_comb begin
    a_d  = a_q;
    b_d  = b_q;
    ix_d = ix_q;
    if (ctl.mop == acpu_pkg::M_WRITE) begin
      if (op_idx == AW'(0)) a_d = wdata;
      if (op_idx == AW'(1)) b_d = wdata;
      if (op_idx == AW'(2)) ix_d = wdata;
    end
    if (ctl.ix_inc) begin
      ix_d = (op_idx == AW'(2)) ? wdata + 16'd1 : ix_q + 16'd1;
    end
  end

  // Flags.
  always_comb begin
    z_d = z_q;
    s_d = s_q;
    c_d = c_q;
    f_d = f_q;
    unique case (ctl.flg)
      acpu_pkg::F_ALU: begin
        if (alu_r.wz) z_d = alu_r.z;
        if (alu_r.ws) s_d = alu_r.s;
        if (alu_r.wcf) begin
          c_d = alu_r.c;
          f_d = alu_r.f;
        end
      end
      acpu_pkg::F_LDA: begin
        z_d = n_zero && (a_q == 16'd0);
        if (n_zero) s_d = a_q[15];
      end
      acpu_pkg::F_ZSA: begin
        z_d = (a_q == 16'd0);
        s_d = a_q[15];
      end
      default: ;
    endcase
  end

  // Program counter and halt.
  always_comb begin
    pc_d   = pc_q;
    halt_d = halt_q;
    if (ctl.clr_halt) halt_d = 1'b0;
    unique case (ctl.pc_op)
      acpu_pkg::P_INC:  pc_d = pc_q + 13'd1;
      acpu_pkg::P_LOAD: pc_d = addr_q;
      acpu_pkg::P_BRANCH: begin
        unique case (ir_op)
          acpu_pkg::OP_JMP: pc_d = ir_q[12:0];
          acpu_pkg::OP_JEZ: if (a_q == 16'd0) pc_d = {1'b0, ir_q[11:0]};
          acpu_pkg::OP_JPS: if (a_q != 16'd0 && !a_q[15]) pc_d = {1'b0, ir_q[11:0]};
          acpu_pkg::OP_HLT: halt_d = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= acpu_pkg::U_IDLE;
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      ix_q        <= '0;
      z_q         <= 1'b0;
      s_q         <= 1'b0;
      c_q         <= 1'b0;
      f_q         <= 1'b0;
      halt_q      <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (clearing_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(MEM_DEPTH - 1)) clearing_q <= 1'b0;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      pc_q   <= pc_d;
      a_q    <= a_d;
      b_q    <= b_d;
      ix_q   <= ix_d;
      z_q    <= z_d;
      s_q    <= s_d;
      c_q    <= c_d;
      f_q    <= f_d;
      halt_q <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q   <= address_i;
      data_q   <= data_i;
      rdata_q  <= 16'd0;
      cycles_q <= 3'd0;
    end
    if (ctl.set_ir) begin
      ir_q     <= mem_q;
      cycles_q <= acpu_pkg::op_cycles(acpu_pkg::op_e'(mem_q[15:12]));
    end
    if (ctl.cap_rd) rdata_q <= mem_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_data_o       <= rdata_q;
      program_counter_o <= pc_q;
      accumulator_o     <= a_q;
      zero_flag_o       <= z_q;
      sign_flag_o       <= s_q;
      carry_flag_o      <= c_q;
      overflow_flag_o   <= f_q;
      halted_o          <= halt_q;
      cycles_used_o     <= cycles_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_clear_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> upc_q == acpu_pkg::U_IDLE)
    else $error("sequencer left idle during memory sweep");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> upc_q != acpu_pkg::U_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q == acpu_pkg::U_FIN))
    else $error("result beat raised outside the final step");

  a_cycles_coded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == acpu_pkg::U_DISP) |=>
      (cycles_q == acpu_pkg::CYC_SHORT || cycles_q == acpu_pkg::CYC_MID ||
       cycles_q == acpu_pkg::CYC_LONG))
    else $error("decoded instruction has no valid cycle count");

endmodule

// ----- tb/sv/tb_accumulator_cpu_16bit_core.sv -----
`timescale 1ns / 1ps
// Testbench for accumulator_cpu_16bit_core: directed actions and random programs checked against a scoreboard model.

module tb_accumulator_cpu_16bit_core;
  import acpu_pkg::*;

  localparam int MEM_WORDS    = 8192;
  localparam int ITEM_TARGET  = 1850;
  localparam int STALL_LIMIT  = 40000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 600;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [15:0] rdata;
    logic [12:0] pc;
    logic [15:0] acc;
    logic        zf;
    logic        sf;
    logic        cf;
    logic        ovf;
    logic        halt;
    logic [2:0]  cyc;
  } cpu_view_t;

  class cpu_scoreboard;
    logic [15:0] mem [MEM_WORDS];
    logic [12:0] pc;
    logic        zf, sf, cf, ovf, halt;
    cpu_view_t   expected_views[$];
    int          errors, actions, runs, halted_runs, results;
    bit          op_seen [16];

    function new();
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      {zf, sf, cf, ovf, halt} = '0;
      errors = 0;
      actions = 0;
      runs = 0;
      halted_runs = 0;
      results = 0;
      foreach (op_seen[i]) op_seen[i] = 1'b0;
    endfunction

    task report(string msg);
      if (errors < 60) $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    function void add_to_acc(logic [15:0] b);
      logic [15:0] a;
      logic [16:0] sum;
      a = mem[0];
      sum = {1'b0, a} + {1'b0, b};
      mem[0] = sum[15:0];
      zf = (sum[15:0] == 16'd0);
      sf = sum[15];
      cf = sum[16];
      ovf = ~(a[15] ^ b[15]) & (a[15] ^ sum[15]);
    endfunction

    function void set_zs(logic [15:0] v);
      zf = (v == 16'd0);
      sf = v[15];
    endfunction

    function logic [2:0] run_instruction();
      logic [12:0] at, n, ix;
      logic [15:0] ir, a, v;
      logic [2:0]  cyc;
      op_e         op;
      at = pc;
      ir = mem[at];
      n = {1'b0, ir[11:0]};
      a = mem[0];
      op = op_e'(ir[15:12]);
      ix = mem[2][12:0];
      cyc = CYC_SHORT;
      pc = pc + 13'd1;
      op_seen[ir[15:12]] = 1'b1;
      runs++;
      case (op)
        OP_ADD: add_to_acc(mem[1]);
        OP_CMP: begin
          mem[0] = ~a;
          set_zs(~a);
        end
        OP_LDA, OP_MOV: begin
          v = mem[at + 13'd1];
          if (op == OP_MOV) v = mem[v[12:0]];
          mem[n] = v;
          zf = (n == 13'd0) && (mem[0] == 16'd0);
          if (n == 13'd0) sf = mem[0][15];
          pc = pc + 13'd1;
          cyc = (op == OP_MOV) ? CYC_LONG : CYC_MID;
        end
        OP_JMP: pc = ir[12:0];
        OP_JEZ: if (a == 16'd0) pc = n;
        OP_JPS: if (a != 16'd0 && !a[15]) pc = n;
        OP_HLT: halt = 1'b1;
        OP_INC: add_to_acc(16'h0001);
        OP_DEC: add_to_acc(16'hFFFF);
        OP_AND: begin
          v = a & mem[1];
          mem[0] = v;
          zf = (v == 16'd0);
        end
        OP_IOR: begin
          v = a | mem[1];
          mem[0] = v;
          zf = (v == 16'd0);
        end
        OP_SHL: begin
          v = {a[14:0], 1'b0};
          mem[0] = v;
          set_zs(v);
        end
        OP_SHR: begin
          v = {a[15], a[15:1]};
          mem[0] = v;
          set_zs(v);
        end
        OP_MXF: begin
          v = mem[ix];
          mem[n] = v;
          mem[2] = mem[2] + 16'd1;
          set_zs(mem[0]);
          cyc = CYC_MID;
        end
        default: begin
          v = mem[n];
          mem[ix] = v;
          mem[2] = mem[2] + 16'd1;
          set_zs(mem[0]);
          cyc = CYC_MID;
        end
      endcase
      return cyc;
    endfunction

    function void note_action(kind_e k, logic [12:0] addr, logic [15:0] d);
      cpu_view_t e;
      e = '0;
      actions++;
      case (k)
        KIND_WRITE: mem[addr] = d;
        KIND_READ:  e.rdata = mem[addr];
        KIND_START: begin
          pc = addr;
          halt = 1'b0;
        end
        default: begin
          if (halt) halted_runs++;
          else e.cyc = run_instruction();
        end
      endcase
      e.pc = pc;
      e.acc = mem[0];
      e.zf = zf;
      e.sf = sf;
      e.cf = cf;
      e.ovf = ovf;
      e.halt = halt;
      expected_views.push_back(e);
    endfunction

    task compare(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %h, want %h", results, field, got, want));
    endtask

    task check_result(cpu_view_t got);
      cpu_view_t want;
      results++;
      if (expected_views.size() == 0) begin
        report($sformatf("beat %0d arrived with no action pending", results));
        return;
      end
      want = expected_views.pop_front();
      compare("read_data", got.rdata, want.rdata);
      compare("program_counter", got.pc, want.pc);
      compare("accumulator", got.acc, want.acc);
      compare("zero_flag", got.zf, want.zf);
      compare("sign_flag", got.sf, want.sf);
      compare("carry_flag", got.cf, want.cf);
      compare("overflow_flag", got.ovf, want.ovf);
      compare("halted", got.halt, want.halt);
      compare("cycles_used", got.cyc, want.cyc);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [12:0] in_address = '0;
  logic [15:0] in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] read_data;
  logic [12:0] program_counter;
  logic [15:0] accumulator;
  logic        zero_flag, sign_flag, carry_flag, overflow_flag, halted;
  logic [2:0]  cycles_used;
  cpu_view_t   seen_view;

  cpu_scoreboard sb;
  int          accepted_in = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  accumulator_cpu_16bit_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (in_kind),
    .address_i         (in_address),
    .data_i            (in_data),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .read_data_o       (read_data),
    .program_counter_o (program_counter),
    .accumulator_o     (accumulator),
    .zero_flag_o       (zero_flag),
    .sign_flag_o       (sign_flag),
    .carry_flag_o      (carry_flag),
    .overflow_flag_o   (overflow_flag),
    .halted_o          (halted),
    .cycles_used_o     (cycles_used)
  );

  assign seen_view = {read_data, program_counter, accumulator, zero_flag, sign_flag,
                      carry_flag, overflow_flag, halted, cycles_used};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(seen_view);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern, with one long hold-off to back up the input
  initial begin : rx_pattern
    int span, mode;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && accepted_in >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(4, 40);
        mode = $urandom_range(0, 3);
        repeat (span) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 5) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_action(kind_e k, logic [12:0] addr, logic [15:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= k;
    in_address <= addr;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_action(k, addr, d);
    accepted_in++;
  endtask

  task automatic run_beat();
    send_action(KIND_RUN, 13'($urandom), 16'($urandom));
  endtask

  task automatic directed_actions();
    send_action(KIND_WRITE, 13'd2, 16'h0002);
    // B holds a halt word, reached after the load wraps the program counter
    send_action(KIND_WRITE, 13'd1, {OP_HLT, 12'h000});
    send_action(KIND_WRITE, 13'h1FFB, {OP_CMP, 12'h000});
    send_action(KIND_WRITE, 13'h1FFC, {OP_INC, 12'h000});
    send_action(KIND_WRITE, 13'h1FFD, {OP_DEC, 12'h000});
    send_action(KIND_WRITE, 13'h1FFE, {OP_MXT, 12'h000});
    send_action(KIND_WRITE, 13'h1FFF, {OP_LDA, 12'h003});
    send_action(KIND_START, 13'h1FFB, 16'hFFFF);
    repeat (7) run_beat();
    send_action(KIND_READ, 13'd3, 16'h0000);
    send_action(KIND_READ, 13'h1FFF, 16'hFFFF);
    send_action(KIND_WRITE, 13'h0FFF, {OP_JMP, 12'hFFF});
    send_action(KIND_START, 13'h0FFF, 16'h0000);
    run_beat();
    send_action(KIND_WRITE, 13'd0, 16'h0000);
    send_action(KIND_START, 13'h0100, 16'h0000);
    run_beat();
    send_action(KIND_WRITE, 13'd4, 16'hFFFF);
    send_action(KIND_READ, 13'd4, 16'h0000);
  endtask

  function automatic logic [15:0] random_instruction(logic [12:0] base, int len);
    logic [3:0]  op;
    logic [11:0] n;
    op = 4'($urandom_range(0, 15));
    if (op == OP_HLT && $urandom_range(0, 2) != 0) op = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0, 1: n = 12'($urandom_range(0, 15));
      2: n = 12'(base + 13'($urandom_range(0, len)));
      default: n = 12'($urandom);
    endcase
    return {op, n};
  endfunction

  task automatic run_program();
    logic [12:0] base;
    int len, steps;
    len = $urandom_range(3, 12);
    if ($urandom_range(0, 7) == 0) base = 13'h1FFF - 13'($urandom_range(0, len));
    else base = 13'($urandom_range(3, 4000));
    if ($urandom_range(0, 1)) send_action(KIND_WRITE, 13'd0, 16'($urandom));
    if ($urandom_range(0, 1)) send_action(KIND_WRITE, 13'd1, 16'($urandom));
    if ($urandom_range(0, 1))
      send_action(KIND_WRITE, 13'd2, ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                  16'(base + 13'($urandom_range(0, len))));
    repeat ($urandom_range(0, 2))
      send_action(KIND_WRITE, 13'($urandom_range(3, 15)), 16'($urandom));
    for (int i = 0; i < len; i++)
      send_action(KIND_WRITE, base + 13'(i), random_instruction(base, len));
    send_action(KIND_START, base, 16'($urandom));
    steps = len + $urandom_range(0, 4);
    repeat (steps) begin
      if ($urandom_range(0, 9) == 0) send_action(KIND_READ, 13'($urandom), 16'($urandom));
      else run_beat();
    end
  endtask

  initial begin : stimulus
    int ops_covered;
    sb = new();
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    directed_actions();
    while (accepted_in < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0)
        send_action(kind_e'($urandom_range(0, 3)), 13'($urandom), 16'($urandom));
      else
        run_program();
    end
    in_valid <= 1'b0;
    while (sb.expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    ops_covered = 0;
    foreach (sb.op_seen[i]) ops_covered += sb.op_seen[i];
    $display("Summary: %0d actions sent, %0d instructions executed (%0d of 16 opcodes),",
             sb.actions, sb.runs, ops_covered);
    $display("         %0d runs while halted, %0d result beats checked, %0d mismatches",
             sb.halted_runs, sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
